// ===== rtl/core/slew_and_accel_limiter_core_macros.svh =====
// ----------------------------------------------------------------------------
// Slew and acceleration limiter assertion macros
// Shared wrappers for the clocked checks in the limiter RTL.
// ----------------------------------------------------------------------------
`ifndef SLEW_AND_ACCEL_LIMITER_CORE_MACROS_SVH
`define SLEW_AND_ACCEL_LIMITER_CORE_MACROS_SVH

// Clocked check, switched off while reset is held
`define SAL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication with the consequent in the next cycle
`define SAL_ASSERT_NEXT(label, ante, cons, msg) \
  `SAL_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ===== rtl/core/sal_pkg.sv =====
// ----------------------------------------------------------------------------
// Slew and acceleration limiter package
// Configuration register map, widths and reset values.
// ----------------------------------------------------------------------------
package sal_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  typedef logic [CFG_DATA_W-1:0] cfg_word_t;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_STEP  = 2'd0,
    REG_MAX_ACCEL = 2'd1,
    REG_PULL_STEP = 2'd2
  } cfg_reg_t;

  // Reset values, unsigned Q15.16
  localparam cfg_word_t MAX_STEP_RST  = 31'd65536;
  localparam cfg_word_t MAX_ACCEL_RST = 31'd6554;
  localparam cfg_word_t PULL_STEP_RST = 31'd6554;

endpackage

// ===== rtl/core/sal_ref_if.sv =====
// ----------------------------------------------------------------------------
// Reference sample channel
// Valid/ready stream carrying one reference sample per item.
// ----------------------------------------------------------------------------
interface sal_ref_if #(
  parameter int WIDTH = 32
) ();
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] reference_sample;

  modport source (output valid, output reference_sample, input ready);
  modport sink   (input valid, input reference_sample, output ready);
endinterface

// ===== rtl/core/sal_lim_if.sv =====
// ----------------------------------------------------------------------------
// Limited sample channel
// Valid/ready stream carrying one limited output sample per item.
// ----------------------------------------------------------------------------
interface sal_lim_if #(
  parameter int WIDTH = 32
) ();
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] limited_sample;

  modport source (output valid, output limited_sample, input ready);
  modport sink   (input valid, input limited_sample, output ready);
endinterface

// ===== rtl/core/slew_and_accel_limiter_core.sv =====
// ----------------------------------------------------------------------------
// Slew and acceleration limiter core
// The result is registered into the output register on accept.
// Throughput: one item per cycle while the output is not stalled; the output
// feedback loop (two multipliers, compare, select, saturate) is combinational.
// Reset: synchronous, clears sample history, output valid and loads the
// default limits.
// ----------------------------------------------------------------------------
`include "slew_and_accel_limiter_core_macros.svh"

module slew_and_accel_limiter_core
  import sal_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  sal_ref_if.sink               in_ref,
  sal_lim_if.source             out_lim,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int W   = SAMPLE_WIDTH;
  // working width: room for 2*y1 - y0 +/- limit and 31-bit limits
  localparam int XW  = ((W > CFG_DATA_W) ? W : CFG_DATA_W) + 3;
  localparam int PLW = W + 1 + CFG_DATA_W + 1;
  localparam int PRW = 2 * (W + 2);
  localparam int MW  = (PLW > PRW) ? PLW : PRW;

  localparam logic signed [XW-1:0] SAT_HI = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] SAT_LO = ~SAT_HI;

  // configuration
  cfg_word_t max_step_r, max_accel_r, pull_step_r;

  // sample history and output
  logic signed [W-1:0] last_reference_r;
  logic signed [W-1:0] last_output_r;
  logic signed [W-1:0] older_output_r;
  logic                out_valid_r;
  logic signed [W-1:0] result_nxt;

  logic in_fire;

  // handshake: output register frees as it drains
  assign in_ref.ready           = !out_valid_r || out_lim.ready;
  assign in_fire                = in_ref.valid && in_ref.ready;
  assign out_lim.valid          = out_valid_r;
  assign out_lim.limited_sample = last_output_r;

  // limiter datapath
  logic signed [XW-1:0] r1_x, r0_x, y1_x, y0_x;
  logic signed [XW-1:0] din, da, dd, ee;
  logic signed [XW-1:0] ms_x, ma_x, ps_x;
  logic        [W:0]    abs_e;
  logic        [W+1:0]  abs_d;
  logic        [MW-1:0] prod_e, prod_d;
  logic                 pull, up;
  logic signed [XW-1:0] step, acc, cand;

  assign r1_x = XW'(in_ref.reference_sample);
  assign r0_x = XW'(last_reference_r);
  assign y1_x = XW'(last_output_r);
  assign y0_x = XW'(older_output_r);
  assign ms_x = XW'(max_step_r);
  assign ma_x = XW'(max_accel_r);
  assign ps_x = XW'(pull_step_r);

  assign din = r1_x - r0_x;
  assign da  = y1_x - y0_x;
  assign dd  = da - din;
  assign ee  = r0_x - y1_x;

  always_comb begin
    logic signed [XW-1:0] neg_e, neg_d;
    neg_e = -ee;
    neg_d = -dd;
    abs_e = ee[XW-1] ? neg_e[W:0] : ee[W:0];
    abs_d = dd[XW-1] ? neg_d[W+1:0] : dd[W+1:0];
  end

  // overshoot test: |e| * 2a <= d * d
  assign prod_e = MW'(abs_e) * MW'({max_accel_r, 1'b0});
  assign prod_d = MW'(abs_d) * MW'(abs_d);
  assign pull   = (ee != '0) && (prod_e <= prod_d);
  assign up     = (r1_x > y1_x) ? (din >= da) : (din > da);

  assign step = pull ? (up ? ps_x : -ps_x) : (r1_x - y1_x);
  assign acc  = step - da;

  // step clamp, then acceleration clamp which takes precedence
  always_comb begin
    cand = y1_x + step;
    if (step > ms_x) begin
      cand = y1_x + ms_x;
    end
    if (step < -ms_x) begin
      cand = y1_x - ms_x;
    end
    if (acc > ma_x) begin
      cand = (y1_x <<< 1) - y0_x + ma_x;
    end
    if (acc < -ma_x) begin
      cand = (y1_x <<< 1) - y0_x - ma_x;
    end
  end

  // saturate to the sample width
  always_comb begin
    if (cand > SAT_HI) begin
      result_nxt = SAT_HI[W-1:0];
    end else if (cand < SAT_LO) begin
      result_nxt = SAT_LO[W-1:0];
    end else begin
      result_nxt = cand[W-1:0];
    end
  end

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_step_r  <= MAX_STEP_RST;
      max_accel_r <= MAX_ACCEL_RST;
      pull_step_r <= PULL_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MAX_STEP:  max_step_r  <= cfg_data;
        REG_MAX_ACCEL: max_accel_r <= cfg_data;
        REG_PULL_STEP: pull_step_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // history and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_reference_r <= '0;
      last_output_r    <= '0;
      older_output_r   <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (in_fire) begin
        last_reference_r <= in_ref.reference_sample;
        last_output_r    <= result_nxt;
        older_output_r   <= last_output_r;
        out_valid_r      <= 1'b1;
      end else if (out_lim.ready) begin
        out_valid_r      <= 1'b0;
      end
    end
  end

  // checks
  `SAL_ASSERT_NEXT(a_fire_gives_result, in_fire, out_valid_r, "accepted item produced no result")
  `SAL_ASSERT_NEXT(a_history_shift, in_fire, older_output_r == $past(last_output_r), "output history not shifted")
  `SAL_ASSERT_NEXT(a_ref_capture, in_fire, last_reference_r == $past(in_ref.reference_sample), "reference not captured")
  `SAL_ASSERT_NEXT(a_hold_when_idle, !in_fire, $stable(last_output_r) && $stable(older_output_r), "state moved without an item")

endmodule

// ===== dv/tb_slew_and_accel_limiter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slew and acceleration limiter core testbench
// Feeds reference samples through randomly throttled valid/ready channels and
// checks every limited sample against a cycle-free predictor of the limiter,
// over several limit settings that include the extremes and a zero
// acceleration limit.
// ----------------------------------------------------------------------------
module tb_slew_and_accel_limiter_core;
  import sal_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic signed [31:0] SAMPLE_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] SAMPLE_MIN = 32'sh80000000;
  localparam cfg_word_t LIMIT_TOP = 31'h7fffffff;

  typedef enum {SEG_HOLD, SEG_RAMP, SEG_WALK, SEG_NOISE, SEG_EXTREME} seg_kind_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sal_ref_if #(.WIDTH(32)) ref_ch ();
  sal_lim_if #(.WIDTH(32)) lim_ch ();

  slew_and_accel_limiter_core #(.SAMPLE_WIDTH(32)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ref    (ref_ch),
    .out_lim   (lim_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Predictor copy of the limits and sample history
  cfg_word_t lim_max_step  = MAX_STEP_RST;
  cfg_word_t lim_max_accel = MAX_ACCEL_RST;
  cfg_word_t lim_pull_step = PULL_STEP_RST;
  longint    prev_ref      = 0;
  longint    last_lim      = 0;
  longint    older_lim     = 0;

  logic signed [31:0] pending_refs[$];
  logic signed [31:0] expected_lims[$];
  int                 fail_count = 0;
  bit                 steady     = 1'b0;

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return SAMPLE_MAX;
    if (v < -64'sd2147483648) return SAMPLE_MIN;
    return v[31:0];
  endfunction

  // Works out the next limited sample and moves the history on
  function automatic logic signed [31:0] advance_limiter(logic signed [31:0] ref_in);
    longint r0, r1, y0, y1, din, da, rel, gap, ms, ma, ps, cand, stp, acc;
    logic [63:0]  mag_gap, mag_rel;
    logic [127:0] lhs, rhs;
    bit up;
    logic signed [31:0] res;
    r0   = prev_ref;
    r1   = longint'(ref_in);
    y0   = older_lim;
    y1   = last_lim;
    din  = r1 - r0;
    da   = y1 - y0;
    rel  = da - din;
    gap  = r0 - y1;
    ms   = longint'(lim_max_step);
    ma   = longint'(lim_max_accel);
    ps   = longint'(lim_pull_step);
    cand = r1;
    // overshoot test by cross-multiplication: |e| * 2a <= d * d
    mag_gap = (gap < 0) ? -gap : gap;
    mag_rel = (rel < 0) ? -rel : rel;
    lhs = 128'(mag_gap) * 128'(2 * ma);
    rhs = 128'(mag_rel) * 128'(mag_rel);
    if (gap != 0 && lhs <= rhs) begin
      if (r1 > y1) up = !(din < da);
      else up = (din > da);
      cand = up ? y1 + ps : y1 - ps;
    end
    // step clamp, then acceleration clamp on the unclamped step
    stp = cand - y1;
    acc = stp - da;
    if (stp > ms) cand = y1 + ms;
    if (stp < -ms) cand = y1 - ms;
    if (acc > ma) cand = 2 * y1 - y0 + ma;
    if (acc < -ma) cand = 2 * y1 - y0 - ma;
    res       = clip32(cand);
    older_lim = y1;
    last_lim  = longint'(res);
    prev_ref  = r1;
    return res;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Driver: one reference item per handshake, gaps between items
  int send_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      ref_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (ref_ch.valid && ref_ch.ready)
        expected_lims.push_back(advance_limiter(ref_ch.reference_sample));
      if (!ref_ch.valid || ref_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          ref_ch.valid <= 1'b0;
        end else if (pending_refs.size() > 0) begin
          ref_ch.valid            <= 1'b1;
          ref_ch.reference_sample <= pending_refs.pop_front();
          send_gap = pick_gap();
        end else begin
          ref_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, compare against the oldest expectation
  int stall_left;
  always @(posedge clk) begin
    logic signed [31:0] want;
    if (!rst_n) begin
      lim_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (lim_ch.valid && lim_ch.ready) begin
        if (expected_lims.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected limited item: got %0d", lim_ch.limited_sample);
          fail_count++;
        end else begin
          want = expected_lims.pop_front();
          if (lim_ch.limited_sample !== want) begin
            if (fail_count < 10)
              $display("limited_sample mismatch: expected %0d, got %0d",
                       want, lim_ch.limited_sample);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        lim_ch.ready <= 1'b0;
      end else begin
        lim_ch.ready <= 1'b1;
        if (!steady && $urandom_range(0, 9) == 0) stall_left = pick_gap();
      end
    end
  end

  // Register write; the predictor takes the new value at once since the
  // block is idle whenever this runs
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, cfg_word_t value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_MAX_STEP:  lim_max_step  = value;
      REG_MAX_ACCEL: lim_max_accel = value;
      REG_PULL_STEP: lim_pull_step = value;
      default: ;
    endcase
  endtask

  task automatic set_limits(cfg_word_t ms, cfg_word_t ma, cfg_word_t ps);
    write_reg(REG_MAX_STEP, ms);
    write_reg(REG_MAX_ACCEL, ma);
    write_reg(REG_PULL_STEP, ps);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_refs.size() != 0 || ref_ch.valid || expected_lims.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  function automatic cfg_word_t pick_limit();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return LIMIT_TOP;
      2:       return cfg_word_t'($urandom_range(1, 1 << 12));
      3:       return cfg_word_t'($urandom_range(1, 1 << 20));
      default: return cfg_word_t'($urandom());
    endcase
  endfunction

  function automatic longint rand_around(longint span);
    longint mag;
    mag = longint'($urandom()) % (span + 1);
    return $urandom_range(0, 1) ? mag : -mag;
  endfunction

  // Reference trajectories: holds, ramps and walks, with some noise and
  // rail-to-rail jumps mixed in
  task automatic queue_trajectory(int count, longint span);
    longint    level;
    longint    slope;
    int        seg_len;
    int        r;
    seg_kind_t kind;
    level = rand_around(span);
    while (count > 0) begin
      r = $urandom_range(0, 99);
      kind = (r < 25) ? SEG_HOLD : (r < 55) ? SEG_RAMP : (r < 85) ? SEG_WALK :
             (r < 95) ? SEG_NOISE : SEG_EXTREME;
      seg_len = $urandom_range(3, 40);
      if (seg_len > count) seg_len = count;
      slope = rand_around(span / 8 + 1);
      if (kind == SEG_HOLD) level = longint'(clip32(level + rand_around(span)));
      repeat (seg_len) begin
        case (kind)
          SEG_RAMP:  level = longint'(clip32(level + slope));
          SEG_WALK:  level = longint'(clip32(level + rand_around(span / 16 + 1)));
          SEG_NOISE: level = longint'($signed($urandom()));
          SEG_EXTREME: begin
            case ($urandom_range(0, 3))
              0:       level = SAMPLE_MAX;
              1:       level = SAMPLE_MIN;
              2:       level = 0;
              default: level = -1;
            endcase
          end
          default: ;
        endcase
        pending_refs.push_back(level[31:0]);
      end
      count -= seg_len;
    end
  endtask

  function automatic longint pick_span();
    return 64'sd1 << $urandom_range(8, 31);
  endfunction

  // Stimulus sequence
  initial begin
    rst_n                   = 1'b0;
    cfg_we                  = 1'b0;
    cfg_index               = '0;
    cfg_data                = '0;
    ref_ch.valid            = 1'b0;
    ref_ch.reference_sample = '0;
    lim_ch.ready            = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: rails, small values, then a step held long enough for the
    // output to approach and get pulled near the reference
    pending_refs.push_back(32'sd0);
    pending_refs.push_back(SAMPLE_MAX);
    pending_refs.push_back(SAMPLE_MAX);
    pending_refs.push_back(SAMPLE_MIN);
    pending_refs.push_back(SAMPLE_MIN);
    pending_refs.push_back(-32'sd1);
    pending_refs.push_back(32'sd1);
    pending_refs.push_back(32'sd0);
    repeat (12) pending_refs.push_back(32'sd655360);
    repeat (4) pending_refs.push_back(-32'sd655360);
    wait_drained();

    // Default limits, with a full drain halfway through
    steady = ($urandom_range(0, 3) == 0);
    queue_trajectory(150, 64'sd1 << 20);
    wait_drained();
    queue_trajectory(150, pick_span());
    wait_drained();

    // Widest limits
    set_limits(LIMIT_TOP, LIMIT_TOP, LIMIT_TOP);
    steady = 1'b0;
    queue_trajectory(200, pick_span());
    wait_drained();

    // Tightest limits
    set_limits('0, 31'd1, '0);
    steady = 1'b1;
    queue_trajectory(150, pick_span());
    wait_drained();

    // Zero acceleration limit: pull test holds whenever the gap is non-zero
    set_limits(pick_limit(), '0, pick_limit());
    steady = 1'b0;
    queue_trajectory(150, pick_span());
    wait_drained();

    // Random settings; an unmapped index must leave the limits alone
    repeat (6) begin
      set_limits(pick_limit(), pick_limit(), pick_limit());
      if ($urandom_range(0, 1)) begin
        write_reg(REG_UNUSED, cfg_word_t'($urandom()));
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
      end
      steady = ($urandom_range(0, 4) == 0);
      queue_trajectory(200, pick_span());
      wait_drained();
    end

    repeat (4) @(negedge clk);
    fail_count += expected_lims.size();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== slew_and_accel_limiter_core.f =====
+incdir+rtl/core
rtl/core/sal_pkg.sv
rtl/core/sal_ref_if.sv
rtl/core/sal_lim_if.sv
rtl/core/slew_and_accel_limiter_core.sv
dv/tb_slew_and_accel_limiter_core.sv
